>>> rtl/core/bmh_pkg.sv
// Shared types and codes for the binary min-heap.
package bmh_pkg;

  localparam int unsigned KEY_W = 32;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // Result of one sift-down decision.
  typedef struct packed {
    logic take_right;
    logic stop;
    key_t child;
  } pick_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INS    = 8'b0000_0010,
    S_INS_C  = 8'b0000_0100,
    S_EXT_RD = 8'b0000_1000,
    S_EXT_K  = 8'b0001_0000,
    S_SD_L   = 8'b0010_0000,
    S_SD_R   = 8'b0100_0000,
    S_SD_C   = 8'b1000_0000
  } state_t;

endpackage

>>> rtl/core/bmh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bmh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/bmh_pick.sv
// Sift-down decision: pick the smaller child and decide whether the key stops.
module bmh_pick (
  input  bmh_pkg::key_t  key,
  input  bmh_pkg::key_t  left,
  input  bmh_pkg::key_t  right,
  input  logic           has_right,
  output bmh_pkg::pick_t pick
);

  logic          take_right;
  bmh_pkg::key_t child;

  // The left child wins ties; a key equal to the child keeps moving down.
  assign take_right      = has_right && (right < left);
  assign child           = take_right ? right : left;
  assign pick.take_right = take_right;
  assign pick.child      = child;
  assign pick.stop       = key < child;

endmodule

>>> rtl/core/binary_min_heap.sv
// Binary min-heap. An extract that empties the heap, and a refused operation, are
// answered straight from the idle state. Each sift level does one RAM read on insert and
// two on extract (left, right). One item is in work at a time, so a new item is not taken
// before the last one has its result; start is taken again in the cycle the result shows,
// and the receiver cannot stall.
// Synchronous active-low reset empties the heap; RAM contents are kept and ignored.
module binary_min_heap #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic signed [31:0]                in_value,
  output logic                              out_valid,
  output logic signed [31:0]                out_removed_value,
  output logic signed [31:0]                out_smallest,
  output logic [$clog2(CAPACITY+1)-1:0]     out_entry_total,
  output logic [1:0]                        out_status
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // Child indexes reach 2*CAPACITY, so they carry two bits beyond the address.
  localparam int unsigned KW = AW + 2;

  // Control registers.
  bmh_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  bmh_pkg::key_t    key_r, key_nxt;
  bmh_pkg::key_t    left_r, left_nxt;
  bmh_pkg::key_t    root_r;
  bmh_pkg::key_t    removed_r, removed_nxt;
  bmh_pkg::status_t status_r, status_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;

  // RAM port signals.
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  bmh_pkg::key_t    wr_data;
  logic [AW-1:0]    rd_addr;
  logic [31:0]      rd_raw;
  bmh_pkg::key_t    rd_data;

  // Index arithmetic.
  logic [AW-1:0]    up;
  logic [AW-1:0]    up_up;
  logic [KW-1:0]    kid;
  logic [KW-1:0]    kid_p1;
  logic [KW-1:0]    cnt_k;
  logic [KW-1:0]    sel_kid;
  logic [KW-1:0]    next_kid;
  logic             accept;

  bmh_pkg::pick_t   pick;

  bmh_ram #(
    .WIDTH (bmh_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_data = bmh_pkg::key_t'(rd_raw);

  // The sift-down compare sees the left child from a register and the right
  // child straight from the RAM read port.
  bmh_pick u_pick (
    .key       (key_r),
    .left      (left_r),
    .right     (rd_data),
    .has_right (kid_p1 < cnt_k),
    .pick      (pick)
  );

  assign busy   = (state_r != bmh_pkg::S_IDLE);
  assign accept = start && !busy;

  // Parent of the hole and of the parent, for the insert path.
  assign up       = (pos_r - 1'b1) >> 1;
  assign up_up    = (up - 1'b1) >> 1;
  // Left child of the hole and of the child picked in this level.
  assign kid      = {1'b0, pos_r, 1'b1};
  assign kid_p1   = kid + 1'b1;
  assign cnt_k    = {{(KW-CW){1'b0}}, count_r};
  assign sel_kid  = pick.take_right ? kid_p1 : kid;
  assign next_kid = {1'b0, sel_kid[AW-1:0], 1'b1};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    key_nxt       = key_r;
    left_nxt      = left_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = key_r;
    rd_addr       = '0;

    unique case (state_r)
      bmh_pkg::S_IDLE: begin
        if (accept) begin
          removed_nxt = '0;
          status_nxt  = bmh_pkg::ST_OK;
          if (in_mode == bmh_pkg::MODE_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              status_nxt    = bmh_pkg::ST_FULL;
              out_valid_nxt = 1'b1;
            end else begin
              // The new key starts as a hole at the end of the heap.
              key_nxt   = in_value;
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + 1'b1;
              state_nxt = bmh_pkg::S_INS;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt    = bmh_pkg::ST_EMPTY;
              out_valid_nxt = 1'b1;
            end else begin
              removed_nxt = root_r;
              count_nxt   = count_r - 1'b1;
              if (count_r == CW'(1)) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = bmh_pkg::S_EXT_RD;
              end
            end
          end
        end
      end

      bmh_pkg::S_INS: begin
        if (pos_r == '0) begin
          wr_en         = 1'b1;
          state_nxt     = bmh_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          rd_addr   = up;
          state_nxt = bmh_pkg::S_INS_C;
        end
      end

      bmh_pkg::S_INS_C: begin
        if (key_r < rd_data) begin
          // The parent moves down into the hole; the hole moves up.
          wr_en   = 1'b1;
          wr_data = rd_data;
          pos_nxt = up;
          if (up == '0) begin
            state_nxt = bmh_pkg::S_INS;
          end else begin
            rd_addr = up_up;
          end
        end else begin
          wr_en         = 1'b1;
          state_nxt     = bmh_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end

      bmh_pkg::S_EXT_RD: begin
        // The count already excludes the removed root, so it indexes the last entry.
        rd_addr   = count_r[AW-1:0];
        state_nxt = bmh_pkg::S_EXT_K;
      end

      bmh_pkg::S_EXT_K: begin
        key_nxt   = rd_data;
        pos_nxt   = '0;
        state_nxt = bmh_pkg::S_SD_L;
      end

      bmh_pkg::S_SD_L: begin
        if (kid < cnt_k) begin
          rd_addr   = kid[AW-1:0];
          state_nxt = bmh_pkg::S_SD_R;
        end else begin
          wr_en         = 1'b1;
          state_nxt     = bmh_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end

      bmh_pkg::S_SD_R: begin
        left_nxt  = rd_data;
        rd_addr   = kid_p1[AW-1:0];
        state_nxt = bmh_pkg::S_SD_C;
      end

      bmh_pkg::S_SD_C: begin
        wr_en = 1'b1;
        if (pick.stop) begin
          state_nxt     = bmh_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          // The smaller child moves up into the hole; fetch the next left child.
          wr_data = pick.child;
          pos_nxt = sel_kid[AW-1:0];
          if (next_kid < cnt_k) begin
            rd_addr   = next_kid[AW-1:0];
            state_nxt = bmh_pkg::S_SD_R;
          end else begin
            state_nxt = bmh_pkg::S_SD_L;
          end
        end
      end

      default: begin
        state_nxt = bmh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmh_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The root is mirrored in a register on every write to slot zero, so the
  // current minimum never costs a RAM read.
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    left_r    <= left_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    pos_r     <= pos_nxt;
    if (wr_en && (wr_addr == '0)) begin
      root_r <= wr_data;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = removed_r;
  assign out_smallest      = (count_r == '0) ? '0 : root_r;
  assign out_entry_total   = count_r;
  assign out_status        = status_r;

  // A result is only shown once the sequencer is back at rest.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while an operation is still in work");

  // An extract on an empty heap is answered in the next cycle with its status.
  a_empty_extract: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == bmh_pkg::MODE_EXTRACT) && (count_r == '0))
      |=> (out_valid && (out_status == bmh_pkg::ST_EMPTY)))
    else $error("extract from empty heap not flagged");

  // The fill count never passes the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // Children fetched during a sift-down always lie inside the heap.
  a_kid_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == bmh_pkg::S_SD_R) || (state_r == bmh_pkg::S_SD_C)) |-> (kid < cnt_k))
    else $error("sift-down child outside the heap");

endmodule

>>> bench/binary_min_heap_test.sv
// Self-checking testbench for the binary min-heap: directed table, then random traffic.
`timescale 1ns / 100ps

module binary_min_heap_test;

  localparam int HEAP_DEPTH = 1024;
  localparam int TOTAL_W = $clog2(HEAP_DEPTH + 1);
  localparam bmh_pkg::key_t KEY_MIN = 32'sh8000_0000;
  localparam bmh_pkg::key_t KEY_MAX = 32'sh7fff_ffff;

  // A stalled run is declared after this many cycles with no transfer on either side.
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_GAP = 30;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int TAIL_CYCLES = 40;

  // One result as the block reports it.
  typedef struct packed {
    bmh_pkg::key_t removed;
    bmh_pkg::key_t smallest;
    logic [TOTAL_W-1:0] total;
    bmh_pkg::status_t status;
  } heap_result_t;

  // One row of the directed table. When "typed" is set, the expected result is taken from
  // the row itself rather than from the predictor.
  typedef struct {
    logic mode;
    bmh_pkg::key_t value;
    logic typed;
    heap_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_mode = bmh_pkg::MODE_INSERT;
  bmh_pkg::key_t in_value = '0;
  logic busy;
  logic out_valid;
  bmh_pkg::key_t out_removed_value;
  bmh_pkg::key_t out_smallest;
  logic [TOTAL_W-1:0] out_entry_total;
  logic [1:0] out_status;

  // Side information that travels with the item currently on the input ports.
  logic want_typed = 1'b0;
  heap_result_t want_fixed = '0;

  // Predictor state: the heap as the block should hold it.
  bmh_pkg::key_t heap_keys [HEAP_DEPTH];
  int heap_size = 0;
  int peak_size = 0;

  heap_result_t pending_results [$];
  int transfers = 0;
  int results_seen = 0;
  int errors = 0;
  int idle_pct = 0;
  int stall_cycles = 0;
  int n_inserts = 0;
  int n_refused_full = 0;
  int n_extracts = 0;
  int n_refused_empty = 0;

  binary_min_heap #(
    .CAPACITY(HEAP_DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_removed_value(out_removed_value),
    .out_smallest(out_smallest),
    .out_entry_total(out_entry_total),
    .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one line per mismatch (the first few dozen) and counts every one.
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  // Applies one operation to the predicted heap and returns the result it should produce.
  // An insert sifts the new key up while it is strictly below its parent; an extract moves
  // the last key to the root and sifts it down, preferring the left child on a tie and
  // sinking below a child that equals it.
  function automatic heap_result_t heap_apply(input logic m, input bmh_pkg::key_t v);
    heap_result_t res;
    bmh_pkg::key_t moving;
    int pos;
    int kid;
    res = '0;
    res.status = bmh_pkg::ST_OK;
    if (m == bmh_pkg::MODE_INSERT) begin
      if (heap_size >= HEAP_DEPTH) begin
        res.status = bmh_pkg::ST_FULL;
      end else begin
        pos = heap_size;
        while (pos > 0 && v < heap_keys[(pos - 1) / 2]) begin
          heap_keys[pos] = heap_keys[(pos - 1) / 2];
          pos = (pos - 1) / 2;
        end
        heap_keys[pos] = v;
        heap_size++;
      end
    end else begin
      if (heap_size == 0) begin
        res.status = bmh_pkg::ST_EMPTY;
      end else begin
        res.removed = heap_keys[0];
        heap_size--;
        if (heap_size > 0) begin
          moving = heap_keys[heap_size];
          pos = 0;
          kid = 1;
          while (kid < heap_size) begin
            if (kid + 1 < heap_size && heap_keys[kid + 1] < heap_keys[kid]) begin
              kid++;
            end
            if (moving < heap_keys[kid]) begin
              break;
            end
            heap_keys[pos] = heap_keys[kid];
            pos = kid;
            kid = 2 * pos + 1;
          end
          heap_keys[pos] = moving;
        end
      end
    end
    if (heap_size > peak_size) begin
      peak_size = heap_size;
    end
    res.smallest = (heap_size > 0) ? heap_keys[0] : '0;
    res.total = heap_size[TOTAL_W-1:0];
    return res;
  endfunction

  // Keys are a mix of the range extremes, a narrow band that makes many duplicates, and
  // fully random patterns so that every bit takes both values.
  function automatic bmh_pkg::key_t random_key();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return bmh_pkg::key_t'(0);
          3: return bmh_pkg::key_t'(-1);
          default: return bmh_pkg::key_t'(1);
        endcase
      end
      1, 2, 3: return bmh_pkg::key_t'($urandom_range(16)) - 8;
      default: return bmh_pkg::key_t'($urandom);
    endcase
  endfunction

  function automatic dir_row_t make_row(input logic m, input bmh_pkg::key_t v,
                                        input logic typed, input bmh_pkg::key_t rem,
                                        input bmh_pkg::key_t sm, input int tot,
                                        input bmh_pkg::status_t st);
    dir_row_t r;
    r.mode = m;
    r.value = v;
    r.typed = typed;
    r.want.removed = rem;
    r.want.smallest = sm;
    r.want.total = tot[TOTAL_W-1:0];
    r.want.status = st;
    return r;
  endfunction

  // Presents one item and returns at the falling edge after its transfer. The call is made
  // at a falling edge. A random gap with start low comes first, during which the data ports
  // carry noise; start stays high from one item to the next when there is no gap.
  task automatic drive_item(input logic m, input bmh_pkg::key_t v, input logic typed,
                            input heap_result_t want);
    int gap;
    int target;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      in_mode <= 1'($urandom_range(1));
      in_value <= bmh_pkg::key_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_value <= v;
    want_typed <= typed;
    want_fixed <= want;
    target = transfers + 1;
    do @(negedge clk); while (transfers < target);
  endtask

  // Monitor: sampled at the rising edge, so every value seen is the one settled during the
  // cycle that the edge ends. A result showing in the same cycle as a new input transfer
  // belongs to the previous item, so it is checked before the new expectation is queued.
  always @(posedge clk) begin
    heap_result_t want;
    heap_result_t model;
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result strobe with no operation outstanding");
        end else begin
          want = pending_results.pop_front();
          if (out_removed_value !== want.removed) begin
            report_mismatch($sformatf("removed_value expected %0d got %0d",
                                      want.removed, out_removed_value));
          end
          if (out_smallest !== want.smallest) begin
            report_mismatch($sformatf("smallest expected %0d got %0d",
                                      want.smallest, out_smallest));
          end
          if (out_entry_total !== want.total) begin
            report_mismatch($sformatf("entry_total expected %0d got %0d",
                                      want.total, out_entry_total));
          end
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, out_status));
          end
        end
      end
      if (start && !busy) begin
        model = heap_apply(in_mode, in_value);
        pending_results.push_back(want_typed ? want_fixed : model);
        transfers++;
        if (in_mode == bmh_pkg::MODE_INSERT) begin
          n_inserts++;
          if (model.status == bmh_pkg::ST_FULL) n_refused_full++;
        end else begin
          n_extracts++;
          if (model.status == bmh_pkg::ST_EMPTY) n_refused_empty++;
        end
      end
    end
  end

  // Watchdog: the run is stuck if neither side transfers for too long.
  always @(posedge clk) begin
    if (rst_n && !(start && !busy) && !out_valid) begin
      stall_cycles++;
    end else begin
      stall_cycles = 0;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
               stall_cycles, pending_results.size());
      $display("binary_min_heap_test: FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    int idle_plan [3];
    int ext_pct;
    logic m;
    idle_plan = '{0, 76, 23};

    // Directed table. Rows with a typed result are the ones whose answer is obvious:
    // the empty heap and its refusal code, and the range extremes.
    rows.push_back(make_row(bmh_pkg::MODE_EXTRACT, 32'sd77, 1'b1, 0, 0, 0, bmh_pkg::ST_EMPTY));
    rows.push_back(make_row(bmh_pkg::MODE_INSERT, 0, 1'b1, 0, 0, 1, bmh_pkg::ST_OK));
    rows.push_back(make_row(bmh_pkg::MODE_INSERT, KEY_MAX, 1'b1, 0, 0, 2, bmh_pkg::ST_OK));
    rows.push_back(make_row(bmh_pkg::MODE_INSERT, KEY_MIN, 1'b1, 0, KEY_MIN, 3,
                            bmh_pkg::ST_OK));
    rows.push_back(make_row(bmh_pkg::MODE_INSERT, -1, 1'b0, 0, 0, 0, bmh_pkg::ST_OK));
    // Duplicates: equal keys must not rise past an equal parent.
    rows.push_back(make_row(bmh_pkg::MODE_INSERT, 0, 1'b0, 0, 0, 0, bmh_pkg::ST_OK));
    rows.push_back(make_row(bmh_pkg::MODE_INSERT, -1, 1'b0, 0, 0, 0, bmh_pkg::ST_OK));
    rows.push_back(make_row(bmh_pkg::MODE_INSERT, KEY_MIN, 1'b0, 0, 0, 0, bmh_pkg::ST_OK));
    // Two copies of the minimum: the first extract leaves the other at the root.
    rows.push_back(make_row(bmh_pkg::MODE_EXTRACT, KEY_MAX, 1'b1, KEY_MIN, KEY_MIN, 6,
                            bmh_pkg::ST_OK));
    rows.push_back(make_row(bmh_pkg::MODE_EXTRACT, 0, 1'b0, 0, 0, 0, bmh_pkg::ST_OK));
    rows.push_back(make_row(bmh_pkg::MODE_INSERT, 3, 1'b0, 0, 0, 0, bmh_pkg::ST_OK));
    rows.push_back(make_row(bmh_pkg::MODE_INSERT, 3, 1'b0, 0, 0, 0, bmh_pkg::ST_OK));
    // Drain completely, so the last extracts sink keys past equal children.
    for (int i = 0; i < 7; i++) begin
      rows.push_back(make_row(bmh_pkg::MODE_EXTRACT, bmh_pkg::key_t'($urandom), 1'b0,
                              0, 0, 0, bmh_pkg::ST_OK));
    end
    rows.push_back(make_row(bmh_pkg::MODE_EXTRACT, KEY_MIN, 1'b1, 0, 0, 0, bmh_pkg::ST_EMPTY));
    rows.push_back(make_row(bmh_pkg::MODE_INSERT, KEY_MAX, 1'b1, 0, KEY_MAX, 1,
                            bmh_pkg::ST_OK));
    rows.push_back(make_row(bmh_pkg::MODE_EXTRACT, -1, 1'b1, KEY_MAX, 0, 0, bmh_pkg::ST_OK));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      drive_item(rows[i].mode, rows[i].value, rows[i].typed, rows[i].want);
    end

    // Random part, one phase per sender idling rate. The mix leans toward extracts as the
    // heap grows. The first phase ends by filling the heap to capacity and knocking on it
    // while full, so the later phases work on a deep heap near the full mark.
    for (int p = 0; p < 3; p++) begin
      idle_pct = idle_plan[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (heap_size == 0) begin
          ext_pct = 15;
        end else if (heap_size < 24) begin
          ext_pct = 40;
        end else begin
          ext_pct = 65;
        end
        m = ($urandom_range(99) < ext_pct) ? bmh_pkg::MODE_EXTRACT : bmh_pkg::MODE_INSERT;
        drive_item(m, random_key(), 1'b0, '0);
      end
      if (p == 0) begin
        while (heap_size < HEAP_DEPTH) begin
          drive_item(bmh_pkg::MODE_INSERT, random_key(), 1'b0, '0);
        end
        repeat (3) drive_item(bmh_pkg::MODE_INSERT, random_key(), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    $display("Covered %0d inserts (%0d refused on a full heap) and %0d extracts",
             n_inserts, n_refused_full, n_extracts);
    $display("(%0d on an empty heap); largest heap %0d entries, %0d results checked.",
             n_refused_empty, peak_size, results_seen);
    if (errors == 0) begin
      $display("binary_min_heap_test: PASS");
    end else begin
      $display("binary_min_heap_test: FAIL");
    end
    $finish;
  end

endmodule
